// ===== hdl/dll_pkg.sv =====
// Shared types and codes for the doubly linked list engine.
// No dependencies; imported by the controller, the datapath and the top level.
package dll_pkg;

	// request opcode carried on func
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LINK1,
		ST_LINK2
	} ctrl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // request word accepted, capture it and read the anchor entries
		logic link1;  // first link write cycle
		logic link2;  // second link write cycle, commit pointers and result
	} dll_cmd_t;

endpackage

// ===== hdl/doubly_linked_list_engine.sv =====
// Doubly linked list engine over a pool of NODES slots.
// The result strobe rises from a register after the LINK1 and LINK2 states that follow an
// accepted start; busy is high in those link states, so a new request is taken only in idle.
// The sequence is set by the registered read of the link stores followed by the writes on
// their single write port. The receiver cannot stall; done is high for one cycle, and the
// result word holds on the ports until the next commit.
// Reset clears head, tail and size at once; link and data stores are not cleared.
module doubly_linked_list_engine #(
	parameter int NODES      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [5:0]  anchor_node,
	input  logic        anchor_is_null,
	input  logic [5:0]  new_node,
	input  logic        new_is_null,
	input  logic [31:0] data_value,
	output logic        done,
	output logic        ok,
	output logic [5:0]  result_node,
	output logic [31:0] result_data,
	output logic [6:0]  list_size,
	output logic [5:0]  head_node,
	output logic        head_valid,
	output logic [5:0]  tail_node,
	output logic        tail_valid
);
	import dll_pkg::*;

	dll_cmd_t cmd;

	// sequencer
	dll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// list state and link logic
	dll_datapath #(
		.NODES      (NODES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.func           (func),
		.anchor_node    (anchor_node),
		.anchor_is_null (anchor_is_null),
		.new_node       (new_node),
		.new_is_null    (new_is_null),
		.data_value     (data_value),
		.done           (done),
		.ok             (ok),
		.result_node    (result_node),
		.result_data    (result_data),
		.list_size      (list_size),
		.head_node      (head_node),
		.head_valid     (head_valid),
		.tail_node      (tail_node),
		.tail_valid     (tail_valid)
	);

endmodule

// ===== hdl/dll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instantiated by dll_datapath for the link and data stores.
module dll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/dll_ctrl.sv =====
// Sequencer for the list engine: accept, link states LINK1 and LINK2, back to idle.
// Depends on dll_pkg for the state type and the command struct.
module dll_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output dll_pkg::dll_cmd_t cmd
);
	import dll_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_LINK1;
				end
			end
			ST_LINK1: begin
				cmd.link1 = 1'b1;
				state_d   = ST_LINK2;
			end
			ST_LINK2: begin
				cmd.link2 = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_link_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LINK1) |=> (state_q == ST_LINK2))
		else $error("link1 not followed by link2");
	a_load_then_link: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (cmd.link1 && busy))
		else $error("accepted word not followed by link1");
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.link1, cmd.link2}))
		else $error("more than one command active");
`endif

endmodule

// ===== hdl/dll_datapath.sv =====
// Datapath of the list engine: head, tail and size registers, link and data stores,
// link update logic and result registers. Depends on dll_pkg and dll_ram.
module dll_datapath #(
	parameter int NODES      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dll_pkg::dll_cmd_t cmd,
	input  logic              func,
	input  logic [5:0]        anchor_node,
	input  logic              anchor_is_null,
	input  logic [5:0]        new_node,
	input  logic              new_is_null,
	input  logic [31:0]       data_value,
	output logic              done,
	output logic              ok,
	output logic [5:0]        result_node,
	output logic [31:0]       result_data,
	output logic [6:0]        list_size,
	output logic [5:0]        head_node,
	output logic              head_valid,
	output logic [5:0]        tail_node,
	output logic              tail_valid
);
	import dll_pkg::*;

	localparam int AW = $clog2(NODES);
	localparam int PW = $clog2(NODES + 1);
	localparam logic [PW-1:0] NIL = PW'(NODES);

	// list registers
	logic [PW-1:0] head_q, tail_q, count_q;

	// captured request
	logic                  func_q, ok_q, empty_q;
	logic [PW-1:0]         anc_q, nw_q;
	logic [DATA_WIDTH-1:0] data_q;

	// result registers
	logic                  done_q, ok_out_q;
	logic [5:0]            rnode_q;
	logic [31:0]           rdata_q;

	// request decode
	logic [31:0] anc32, nw32;
	logic [63:0] din64, rd64;
	logic        anc_null, nw_null, cnt_zero, cnt_full, ins_ok, rem_ok, req_ok;
	logic [AW-1:0] rd_addr;

	assign anc32    = 32'(anchor_node);
	assign nw32     = 32'(new_node);
	assign din64    = 64'(data_value);
	assign anc_null = anchor_is_null || !(anc32 < NODES);
	assign nw_null  = new_is_null || !(nw32 < NODES);
	assign cnt_zero = (count_q == '0);
	assign cnt_full = (32'(count_q) >= NODES);
	assign ins_ok   = !(anc_null && !cnt_zero) && !nw_null && !cnt_full;
	assign rem_ok   = !anc_null && !cnt_zero;
	assign req_ok   = (func == FUNC_REMOVE) ? rem_ok : ins_ok;
	assign rd_addr  = anc32[AW-1:0];

	// capture the request word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			ok_q    <= req_ok;
			empty_q <= cnt_zero;
			anc_q   <= anc32[PW-1:0];
			nw_q    <= nw32[PW-1:0];
			data_q  <= din64[DATA_WIDTH-1:0];
		end
	end

	// link and data stores, all read at the anchor on accept
	logic [PW-1:0]         nx_rd, pv_rd;
	logic [DATA_WIDTH-1:0] dat_rd;
	logic                  nx_we, pv_we, dat_we;
	logic [AW-1:0]         nx_wa, pv_wa, dat_wa;
	logic [PW-1:0]         nx_wd, pv_wd;

	dll_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
		.re(cmd.load), .raddr(rd_addr), .rdata(nx_rd)
	);

	dll_ram #(.WIDTH(PW), .DEPTH(NODES)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
		.re(cmd.load), .raddr(rd_addr), .rdata(pv_rd)
	);

	dll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_data (
		.clk(clk), .we(dat_we), .waddr(dat_wa), .wdata(data_q),
		.re(cmd.load), .raddr(rd_addr), .rdata(dat_rd)
	);

	// neighbor decode from the anchor entries
	logic          nx_in, pv_in, is_head, do_ins, do_rem;
	logic [PW-1:0] nx_norm, pv_norm;

	assign nx_in   = (32'(nx_rd) < NODES);
	assign pv_in   = (32'(pv_rd) < NODES);
	assign nx_norm = nx_in ? nx_rd : NIL;
	assign pv_norm = pv_in ? pv_rd : NIL;
	assign is_head = (anc_q == head_q);
	assign do_ins  = ok_q && (func_q == FUNC_INSERT);
	assign do_rem  = ok_q && (func_q == FUNC_REMOVE);
	assign rd64    = 64'(dat_rd);

	// link writes: insert in link1 and, unless the list was empty, in link2; remove only in link1
	always_comb begin
		nx_we  = 1'b0;
		nx_wa  = nw_q[AW-1:0];
		nx_wd  = NIL;
		pv_we  = 1'b0;
		pv_wa  = nw_q[AW-1:0];
		pv_wd  = NIL;
		dat_we = 1'b0;
		dat_wa = nw_q[AW-1:0];
		if (cmd.link1 && do_ins) begin
			dat_we = 1'b1;
			nx_we  = 1'b1;
			pv_we  = 1'b1;
			if (!empty_q) begin
				nx_wd = nx_norm;
				pv_wd = anc_q;
			end
		end else if (cmd.link2 && do_ins && !empty_q) begin
			nx_we = 1'b1;
			nx_wa = anc_q[AW-1:0];
			nx_wd = nw_q;
			pv_we = nx_in;
			pv_wa = nx_rd[AW-1:0];
			pv_wd = nw_q;
		end else if (cmd.link1 && do_rem) begin
			pv_we = nx_in;
			pv_wa = nx_rd[AW-1:0];
			if (is_head) begin
				pv_wd = NIL;
			end else begin
				pv_wd = pv_norm;
				nx_we = pv_in;
				nx_wa = pv_rd[AW-1:0];
				nx_wd = nx_norm;
			end
		end
	end

	// head, tail and size commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NIL;
			tail_q  <= NIL;
			count_q <= '0;
		end else if (cmd.link2 && do_ins) begin
			count_q <= count_q + 1'b1;
			if (empty_q) begin
				head_q <= nw_q;
				tail_q <= nw_q;
			end else if (!nx_in) begin
				tail_q <= nw_q;
			end
		end else if (cmd.link2 && do_rem) begin
			count_q <= count_q - 1'b1;
			if (is_head) begin
				head_q <= nx_norm;
				if (!nx_in) begin
					tail_q <= NIL;
				end
			end else if (!nx_in) begin
				tail_q <= pv_norm;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.link2;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.link2) begin
			ok_out_q <= ok_q;
			rnode_q  <= do_rem ? 6'(anc_q) : 6'd0;
			rdata_q  <= do_rem ? rd64[31:0] : 32'd0;
		end
	end

	assign done        = done_q;
	assign ok          = ok_out_q;
	assign result_node = rnode_q;
	assign result_data = rdata_q;
	assign list_size   = 7'(count_q);
	assign head_valid  = (head_q != NIL);
	assign tail_valid  = (tail_q != NIL);
	assign head_node   = head_valid ? 6'(head_q) : 6'd0;
	assign tail_node   = tail_valid ? 6'(tail_q) : 6'd0;

`ifndef SYNTH
	a_done_after_link2: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.link2))
		else $error("result strobe without a commit cycle");
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= NODES)
		else $error("list size beyond pool");
	a_size_commit_only: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.link2) |-> $stable(count_q))
		else $error("list size changed outside the commit cycle");
`endif

endmodule
